// ----- src/sse_pkg.sv -----
// Package for the sorted set engine: sizes, operation and status codes,
// and the types shared by the cell chain, the top level and the interfaces.
// No dependencies.
package sse_pkg;

   // Store geometry and element width.
   localparam int SLOTS      = 16;
   localparam int VALUE_BITS = 16;
   localparam int COUNT_BITS = $clog2(SLOTS);

   // Fixed field widths of the transaction payloads.
   localparam int OPCODE_BITS = 2;
   localparam int FIELD_BITS  = 16;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_FIELD = 4;

   // Operation codes. The spare code behaves as a find.
   localparam logic [OPCODE_BITS-1:0] OP_FIND   = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_ADD    = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_REMOVE = 2'd2;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_REJECT = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ABSENT = 2'd2;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  occ;
      logic                  ins;
   } link_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic                  load;
      logic                  insert;
      logic                  remove;
      logic [VALUE_BITS-1:0] value;
   } cmd_type;

   // Low four bits of an entry count, zero-extended when the count is narrower.
   function automatic logic [COUNT_FIELD-1:0] count_field(input logic [COUNT_BITS-1:0] n);
      logic [COUNT_BITS+COUNT_FIELD-1:0] wide;
      wide = {{COUNT_FIELD{1'b0}}, n};
      return wide[COUNT_FIELD-1:0];
   endfunction

endpackage

// ----- src/sse_if.sv -----
// Channel interfaces of the sorted set engine: request and response.
// Depends on sse_pkg for the field widths.
interface sse_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [sse_pkg::OPCODE_BITS-1:0]      opcode;
   logic signed [sse_pkg::FIELD_BITS-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sse_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sse_pkg::STATUS_BITS-1:0] status;
   logic                            found;
   logic [sse_pkg::COUNT_FIELD-1:0] count;
   logic                            empty_res;

   modport source (output valid, output status, output found, output count,
                   output empty_res, input ready);
   modport sink   (input valid, input status, input found, input count,
                   input empty_res, output ready);
endinterface

// ----- src/sse_cell.sv -----
// One slot of the sorted store: holds a value, its occupancy bit and the
// compare flags against the broadcast value. Depends on sse_pkg.
module sse_cell (
   input  logic              clock,
   input  logic              reset,
   input  sse_pkg::cmd_type  cmd,
   input  sse_pkg::link_type prev,
   input  sse_pkg::link_type next,
   output sse_pkg::link_type self,
   output logic              hit
);

   logic [sse_pkg::VALUE_BITS-1:0] val_ff, val_in;
   logic                           occ_ff, occ_in;
   logic                           ins_ff, ins_in;
   logic                           hit_ff, hit_in;

   // Compare on load; shift toward the high end on insert, toward the low
   // end on remove. The ins flag marks slots at or past the insertion point.
   always_comb begin
      val_in = val_ff;
      occ_in = occ_ff;
      ins_in = ins_ff;
      hit_in = hit_ff;
      if (cmd.load) begin
         ins_in = !occ_ff || (val_ff > cmd.value);
         hit_in = occ_ff && (val_ff == cmd.value);
      end
      if (cmd.insert) begin
         if (prev.ins) begin
            val_in = prev.value;
            occ_in = prev.occ;
         end else if (ins_ff) begin
            val_in = cmd.value;
            occ_in = 1'b1;
         end
      end
      if (cmd.remove) begin
         if (hit_ff || (occ_ff && ins_ff)) begin
            val_in = next.value;
            occ_in = next.occ;
         end
      end
   end

   // Control bits are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         ins_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         ins_ff <= ins_in;
         hit_ff <= hit_in;
      end
   end

   // The stored value is only meaningful while occupied.
   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign self.value = val_ff;
   assign self.occ   = occ_ff;
   assign self.ins   = ins_ff;
   assign hit        = hit_ff;

endmodule

// ----- src/sorted_set_engine.sv -----
// Sorted set engine top level: sequencer, entry counter, result register
// and the chain of sse_cell slots. Depends on sse_pkg, sse_if and sse_cell.
//
// Keeps up to SLOTS-1 distinct non-negative values in ascending order and
// answers find, add and remove transactions with one response each. In the
// cycle a transaction is accepted its value is broadcast to all cells, which
// register their compare flags; in the execute state the sequencer decides
// the operation from those flags, the cells at or past the insertion or
// removal point shift one step toward their neighbor, and the response is
// written to an output register. No new request is taken until the execute
// state ends; a response that is not taken holds the execute state of the
// following transaction. Reset empties the store at once.
module sorted_set_engine (
   input logic         clock,
   input logic         reset,
   sse_req_if.sink     req_chan,
   sse_rsp_if.source   rsp_chan
);

   localparam sse_pkg::link_type PREV_EDGE = '{value: '0, occ: 1'b1, ins: 1'b0};
   localparam sse_pkg::link_type NEXT_EDGE = '{value: '0, occ: 1'b0, ins: 1'b0};

   sse_pkg::state_type state_ff, state_in;

   logic [sse_pkg::OPCODE_BITS-1:0] op_ff, op_in;
   logic [sse_pkg::VALUE_BITS-1:0]  value_ff, value_in;
   logic [sse_pkg::COUNT_BITS-1:0]  count_ff, count_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sse_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic                            found_ff, found_in;
   logic [sse_pkg::COUNT_BITS-1:0]  rcount_ff, rcount_in;

   logic signed [31:0]              value_wide;
   logic [sse_pkg::VALUE_BITS-1:0]  req_value;
   logic                            req_accept;
   logic                            negative;
   logic                            found;
   logic                            full;
   logic                            do_insert;
   logic                            do_remove;
   logic                            exec_go;

   sse_pkg::cmd_type                cmd;
   sse_pkg::link_type               links [sse_pkg::SLOTS];
   logic [sse_pkg::SLOTS-1:0]       hits;

   // The element is the low VALUE_BITS bits of the sign-extended field.
   assign value_wide = 32'(req_chan.value);
   assign req_value  = value_wide[sse_pkg::VALUE_BITS-1:0];
   assign req_accept = req_chan.valid && req_chan.ready;

   // Decision from the registered cell flags.
   assign negative  = value_ff[sse_pkg::VALUE_BITS-1];
   assign found     = (|hits) && !negative;
   assign full      = (count_ff == sse_pkg::COUNT_BITS'(sse_pkg::SLOTS - 1));
   assign exec_go   = (state_ff == sse_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign do_insert = exec_go && (op_ff == sse_pkg::OP_ADD) && !negative && !found && !full;
   assign do_remove = exec_go && (op_ff == sse_pkg::OP_REMOVE) && found;

   // Broadcast command to the cells.
   always_comb begin
      cmd.load   = req_accept;
      cmd.insert = do_insert;
      cmd.remove = do_remove;
      cmd.value  = (state_ff == sse_pkg::ST_IDLE) ? req_value : value_ff;
   end

   // Chain of cells, each linked to both neighbors.
   for (genvar i = 0; i < sse_pkg::SLOTS; i++) begin : g_cell
      sse_pkg::link_type prev_link;
      sse_pkg::link_type next_link;
      if (i == 0) begin : g_first
         assign prev_link = PREV_EDGE;
      end else begin : g_mid
         assign prev_link = links[i-1];
      end
      if (i == sse_pkg::SLOTS - 1) begin : g_last
         assign next_link = NEXT_EDGE;
      end else begin : g_inner
         assign next_link = links[i+1];
      end
      sse_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .prev  (prev_link),
         .next  (next_link),
         .self  (links[i]),
         .hit   (hits[i])
      );
   end

   // Sequencer, counter and response register next-state logic.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      found_in     = found_ff;
      rcount_in    = rcount_ff;
      unique case (state_ff)
         sse_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in    = req_chan.opcode;
               value_in = req_value;
               state_in = sse_pkg::ST_EXEC;
            end
         end
         sse_pkg::ST_EXEC: begin
            if (exec_go) begin
               if (do_insert) begin
                  count_in = count_ff + 1'b1;
               end else if (do_remove) begin
                  count_in = count_ff - 1'b1;
               end
               if (op_ff == sse_pkg::OP_ADD) begin
                  status_in = do_insert ? sse_pkg::STATUS_DONE : sse_pkg::STATUS_REJECT;
               end else begin
                  status_in = found ? sse_pkg::STATUS_DONE : sse_pkg::STATUS_ABSENT;
               end
               found_in     = found;
               rcount_in    = count_in;
               rsp_valid_in = 1'b1;
               state_in     = sse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sse_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sse_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rcount_ff <= rcount_in;
   end

   // Port drive.
   assign req_chan.ready     = (state_ff == sse_pkg::ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.found     = found_ff;
   assign rsp_chan.count     = sse_pkg::count_field(rcount_ff);
   assign rsp_chan.empty_res = (rcount_ff == '0);

endmodule

// ----- src/sse_checker.sv -----
// Port-level checks for the sorted set engine, bound to its top level.
// Depends on sse_pkg and on sorted_set_engine.
module sse_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [sse_pkg::STATUS_BITS-1:0] rsp_status,
   input logic                            rsp_found,
   input logic [sse_pkg::COUNT_FIELD-1:0] rsp_count,
   input logic                            rsp_empty
);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found)
         && $stable(rsp_count) && $stable(rsp_empty))
      else $error("stalled response changed");

   // Transactions are taken one at a time, never in adjacent cycles.
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   // An empty store reports a zero count.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty |-> rsp_count == '0)
      else $error("empty flag with nonzero count");

   // A present value is never reported absent.
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status != sse_pkg::STATUS_ABSENT)
      else $error("found value reported absent");

endmodule

bind sorted_set_engine sse_checker u_sse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_found  (rsp_chan.found),
   .rsp_count  (rsp_chan.count),
   .rsp_empty  (rsp_chan.empty_res)
);

// ----- sim/tb_sorted_set_engine.sv -----
// Self-checking testbench for sorted_set_engine: directed and random find, add
// and remove transactions, checked against a behavioral model of the sorted set.
// Depends on sse_pkg, sse_if and the sorted_set_engine RTL.
module tb_sorted_set_engine;

   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 8;
   localparam int RANDOM_ITEMS = 800;
   localparam int RECENT_DEPTH = 24;

   // The spare opcode is handled by the block as a find.
   localparam logic [sse_pkg::OPCODE_BITS-1:0] OP_SPARE = 2'd3;

   // Response-side backpressure patterns.
   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_PERIODIC,
      RX_MOSTLY
   } rx_pattern_type;

   typedef struct {
      logic [sse_pkg::OPCODE_BITS-1:0] opcode;
      logic [sse_pkg::FIELD_BITS-1:0]  value;
      bit                              wait_drain;
   } set_request_type;

   typedef struct {
      logic [sse_pkg::STATUS_BITS-1:0] status;
      logic                            found;
      logic [sse_pkg::COUNT_FIELD-1:0] count;
      logic                            empty_res;
   } set_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sse_req_if req_chan ();
   sse_rsp_if rsp_chan ();

   sorted_set_engine dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // Shadow copy of the store: packed, ascending, shadow_n entries in use.
   logic [sse_pkg::VALUE_BITS-1:0] shadow_vals [sse_pkg::SLOTS];
   int                             shadow_n = 0;

   set_request_type                pending_reqs [$];
   set_result_type                 awaited_results [$];
   logic [sse_pkg::FIELD_BITS-1:0] recent_adds [$];

   int unsigned    error_count = 0;
   int unsigned    quiet_cycles = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int unsigned    rsp_cycle = 0;
   rx_pattern_type rx_pattern = RX_OPEN;

   // Applies one operation to the shadow store and returns the response it should give.
   function automatic set_result_type apply_set_op(
         input logic [sse_pkg::OPCODE_BITS-1:0] op,
         input logic [sse_pkg::FIELD_BITS-1:0]  raw);
      logic [sse_pkg::VALUE_BITS-1:0] v;
      bit                             negative;
      int                             hit;
      int                             pos;
      int                             i;
      set_result_type                 r;
      v = raw[sse_pkg::VALUE_BITS-1:0];
      negative = v[sse_pkg::VALUE_BITS-1];
      hit = -1;
      if (!negative) begin
         for (i = 0; i < shadow_n; i++)
            if (shadow_vals[i] == v)
               hit = i;
      end
      r.found = (hit >= 0);
      case (op)
         sse_pkg::OP_ADD: begin
            if (negative || hit >= 0 || shadow_n >= sse_pkg::SLOTS - 1) begin
               r.status = sse_pkg::STATUS_REJECT;
            end else begin
               pos = 0;
               while (pos < shadow_n && shadow_vals[pos] < v)
                  pos++;
               for (i = shadow_n; i > pos; i--)
                  shadow_vals[i] = shadow_vals[i-1];
               shadow_vals[pos] = v;
               shadow_n++;
               r.status = sse_pkg::STATUS_DONE;
            end
         end
         sse_pkg::OP_REMOVE: begin
            if (hit < 0) begin
               r.status = sse_pkg::STATUS_ABSENT;
            end else begin
               for (i = hit; i + 1 < shadow_n; i++)
                  shadow_vals[i] = shadow_vals[i+1];
               shadow_n--;
               r.status = sse_pkg::STATUS_DONE;
            end
         end
         default: begin
            r.status = (hit >= 0) ? sse_pkg::STATUS_DONE : sse_pkg::STATUS_ABSENT;
         end
      endcase
      r.count = shadow_n[sse_pkg::COUNT_FIELD-1:0];
      r.empty_res = (shadow_n == 0);
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want_v,
                                       input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         error_count++;
      end
   endfunction

   function automatic void queue_req(input logic [sse_pkg::OPCODE_BITS-1:0] op,
                                     input logic [sse_pkg::FIELD_BITS-1:0] value,
                                     input bit hold);
      set_request_type t;
      t.opcode = op;
      t.value = value;
      t.wait_drain = hold;
      pending_reqs.push_back(t);
   endfunction

   // Request driver: bursts of transactions separated by random gaps.
   always @(posedge clock) begin
      set_request_type done_req;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            done_req = pending_reqs.pop_front();
            awaited_results.push_back(apply_set_op(done_req.opcode, done_req.value));
         end
         // An offered transaction stays on the bus until it is taken.
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].wait_drain && awaited_results.size() != 0)) begin
               req_chan.valid <= 1'b0;
            end else begin
               req_chan.valid  <= 1'b1;
               req_chan.opcode <= pending_reqs[0].opcode;
               req_chan.value  <= pending_reqs[0].value;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
      end
   end

   // Response monitor: checks each response and applies its own stall pattern.
   always @(posedge clock) begin
      set_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected response: status %0d, count %0d",
                      rsp_chan.status, rsp_chan.count);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_chan.status));
               check_field("found", 32'(want.found), 32'(rsp_chan.found));
               check_field("count", 32'(want.count), 32'(rsp_chan.count));
               check_field("empty_res", 32'(want.empty_res), 32'(rsp_chan.empty_res));
            end
         end
         rsp_cycle++;
         if (rsp_cycle % 64 == 0)
            rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         case (rx_pattern)
            RX_OPEN:     rsp_chan.ready <= 1'b1;
            RX_COIN:     rsp_chan.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp_chan.ready <= (rsp_cycle % 5 > 1);
            default:     rsp_chan.ready <= ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   // Watchdog: ends the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_sorted_set_engine: done, errors");
            $finish;
         end
      end
   end

   initial begin
      logic [sse_pkg::OPCODE_BITS-1:0] op;
      logic [sse_pkg::FIELD_BITS-1:0]  val;
      int                              pick;
      int                              add_cut;
      int                              k;
      bit                              filling;

      req_chan.valid  = 1'b0;
      req_chan.opcode = sse_pkg::OP_FIND;
      req_chan.value  = '0;
      rsp_chan.ready  = 1'b0;

      // Directed: empty store, sign extremes, duplicates and the spare opcode.
      queue_req(sse_pkg::OP_FIND, 16'h0000, 1'b0);
      queue_req(sse_pkg::OP_REMOVE, 16'h0005, 1'b0);
      queue_req(sse_pkg::OP_ADD, 16'hFFFF, 1'b0);
      queue_req(sse_pkg::OP_ADD, 16'h8000, 1'b0);
      queue_req(sse_pkg::OP_ADD, 16'h7FFF, 1'b0);
      queue_req(sse_pkg::OP_ADD, 16'h0000, 1'b0);
      queue_req(sse_pkg::OP_ADD, 16'h0000, 1'b0);
      queue_req(sse_pkg::OP_FIND, 16'h7FFF, 1'b0);
      queue_req(OP_SPARE, 16'h7FFF, 1'b0);
      queue_req(OP_SPARE, 16'h0001, 1'b0);
      queue_req(sse_pkg::OP_REMOVE, 16'hFFFF, 1'b0);
      // Fill to capacity with descending values so each lands in the middle.
      for (k = 0; k < 13; k++)
         queue_req(sse_pkg::OP_ADD, 16'(13000 - 1000 * k), 1'b0);
      // Full store: add is rejected, an absent remove reports not found.
      queue_req(sse_pkg::OP_ADD, 16'h2AAA, 1'b0);
      queue_req(sse_pkg::OP_REMOVE, 16'h5555, 1'b0);
      queue_req(sse_pkg::OP_REMOVE, 16'h0000, 1'b0);

      // Random: phases that lean toward filling or draining, on a small value
      // range so that hits, duplicates, full and empty stores come up often.
      filling = 1'b1;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 40 == 0)
            filling = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            val = 16'($urandom_range(0, 31));
         end else if (pick < 75 && recent_adds.size() > 0) begin
            val = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
         end else if (pick < 92) begin
            val = 16'($urandom());
         end else begin
            case ($urandom_range(0, 4))
               0:       val = 16'h0000;
               1:       val = 16'h7FFF;
               2:       val = 16'h8000;
               3:       val = 16'hFFFF;
               default: val = 16'h0001;
            endcase
         end
         add_cut = filling ? 64 : 24;
         pick = $urandom_range(0, 99);
         if (pick < 4)
            op = OP_SPARE;
         else if (pick < add_cut)
            op = sse_pkg::OP_ADD;
         else if (pick < 80)
            op = sse_pkg::OP_REMOVE;
         else
            op = sse_pkg::OP_FIND;
         if (op == sse_pkg::OP_ADD && !val[sse_pkg::FIELD_BITS-1]) begin
            recent_adds.push_back(val);
            if (recent_adds.size() > RECENT_DEPTH)
               void'(recent_adds.pop_front());
         end
         queue_req(op, val, (k % 200 == 0));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (pending_reqs.size() != 0 || awaited_results.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb_sorted_set_engine: done, clean");
      else
         $display("tb_sorted_set_engine: done, errors");
      $finish;
   end

endmodule
